FILE: rtl/pqta_pkg.sv
// ----------------------------------------------------------------------------
// pqta_pkg
// Shared constants, codes and the command type passed between the admission
// front end, the command queue and the table engine.
// ----------------------------------------------------------------------------
package pqta_pkg;

  localparam int QueueCount    = 64;
  localparam int CountBits     = 10;
  localparam int QidxBits      = (QueueCount > 1) ? $clog2(QueueCount) : 1;
  localparam int QueueFieldBits = 6;
  localparam int CountFieldBits = 10;

  localparam int FifoDepth   = 2;
  localparam int FifoPtrBits = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntBits = $clog2(FifoDepth + 1);

  // operation field codes
  localparam logic [1:0] OP_TRAFFIC   = 2'd0;
  localparam logic [1:0] OP_WRITE_ONE = 2'd1;
  localparam logic [1:0] OP_WRITE_ALL = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  typedef enum logic [1:0] {
    KIND_TRAFFIC,
    KIND_WRITE_ONE,
    KIND_WRITE_ALL,
    KIND_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic                      dq_en;      // dequeue present and queue in range
    logic [QidxBits-1:0]       dq_addr;
    logic                      arr_valid;
    logic                      arr_hit;    // arrival queue in range
    logic [QueueFieldBits-1:0] arr_queue;
    logic [QidxBits-1:0]       arr_addr;
    logic [CountBits-1:0]      thr;
  } cmd_t;

endpackage

FILE: rtl/pqta_front.sv
// ----------------------------------------------------------------------------
// pqta_front
// Takes input requests, decodes the operation and checks queue indexes,
// and pushes a classified command into the command queue.
// ----------------------------------------------------------------------------
module pqta_front (
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic                                 dequeue_valid,
  input  logic [pqta_pkg::QueueFieldBits-1:0]  dequeue_queue,
  input  logic                                 arrival_valid,
  input  logic [pqta_pkg::QueueFieldBits-1:0]  arrival_queue,
  input  logic [pqta_pkg::CountFieldBits-1:0]  threshold_value,
  input  logic                                 fifo_full,
  output logic                                 push,
  output pqta_pkg::cmd_t                       cmd
);

  pqta_pkg::op_kind_t kind;

  always_comb begin
    unique case (operation)
      pqta_pkg::OP_TRAFFIC:   kind = pqta_pkg::KIND_TRAFFIC;
      pqta_pkg::OP_WRITE_ONE: kind = pqta_pkg::KIND_WRITE_ONE;
      pqta_pkg::OP_WRITE_ALL: kind = pqta_pkg::KIND_WRITE_ALL;
      pqta_pkg::OP_CLEAR:     kind = pqta_pkg::KIND_CLEAR;
    endcase
  end

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    cmd.kind      = kind;
    cmd.dq_en     = dequeue_valid && (32'(dequeue_queue) < pqta_pkg::QueueCount);
    cmd.dq_addr   = pqta_pkg::QidxBits'(dequeue_queue);
    cmd.arr_valid = arrival_valid;
    cmd.arr_hit   = 32'(arrival_queue) < pqta_pkg::QueueCount;
    cmd.arr_queue = arrival_queue;
    cmd.arr_addr  = pqta_pkg::QidxBits'(arrival_queue);
    cmd.thr       = pqta_pkg::CountBits'(threshold_value);
  end

endmodule

FILE: rtl/pqta_fifo.sv
// ----------------------------------------------------------------------------
// pqta_fifo
// Short command queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module pqta_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pqta_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pqta_pkg::cmd_t dout
);

  pqta_pkg::cmd_t                     entries [pqta_pkg::FifoDepth];
  logic [pqta_pkg::FifoPtrBits-1:0]   wr_ptr;
  logic [pqta_pkg::FifoPtrBits-1:0]   rd_ptr;
  logic [pqta_pkg::FifoCntBits-1:0]   count;
  logic                               do_push;
  logic                               do_pop;

  localparam logic [pqta_pkg::FifoPtrBits-1:0] LastPtr =
    pqta_pkg::FifoPtrBits'(pqta_pkg::FifoDepth - 1);

  assign full      = count == pqta_pkg::FifoCntBits'(pqta_pkg::FifoDepth);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/pqta_back.sv
// ----------------------------------------------------------------------------
// pqta_back
// Table engine: holds occupancy and threshold tables, applies dequeue
// reports, judges arrivals and drives the result register.
// ----------------------------------------------------------------------------
module pqta_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  pqta_pkg::cmd_t                       head,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 decision_valid,
  output logic [pqta_pkg::QueueFieldBits-1:0]  decision_queue,
  output logic                                 dropped,
  output logic [pqta_pkg::CountFieldBits-1:0]  occupancy_after
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_ARR
  } state_t;

  state_t                           state;
  pqta_pkg::cmd_t                   cmd;

  logic [pqta_pkg::CountBits-1:0]   occ_mem [pqta_pkg::QueueCount];
  logic [pqta_pkg::CountBits-1:0]   thr_mem [pqta_pkg::QueueCount];
  logic [pqta_pkg::QueueCount-1:0]  occ_vld;
  logic [pqta_pkg::QueueCount-1:0]  thr_vld;
  logic [pqta_pkg::CountBits-1:0]   thr_default;

  logic [pqta_pkg::CountBits-1:0]   occ_rd_dq;
  logic [pqta_pkg::CountBits-1:0]   occ_rd_arr;
  logic                             occ_vld_dq;
  logic                             occ_vld_arr;
  logic [pqta_pkg::CountBits-1:0]   thr_rd;
  logic                             thr_vld_rd;
  logic [pqta_pkg::CountBits-1:0]   arr_occ;

  logic [pqta_pkg::CountBits-1:0]   occ_dq_cur;
  logic [pqta_pkg::CountBits-1:0]   occ_dq_dec;
  logic [pqta_pkg::CountBits-1:0]   occ_arr_cur;
  logic [pqta_pkg::CountBits-1:0]   thr_eff;
  logic [pqta_pkg::CountBits-1:0]   occ_inc;
  logic                             same_q;
  logic                             out_free;
  logic                             finish;
  logic                             judged;
  logic                             admit;

  logic                             occ_we;
  logic [pqta_pkg::QidxBits-1:0]    occ_wa;
  logic [pqta_pkg::CountBits-1:0]   occ_wd;
  logic                             thr_we;

  assign pop = (state == S_IDLE) && head_valid;

  // unwritten entries (since reset or a bulk op) read as 0 or thr_default
  assign occ_dq_cur  = occ_vld_dq  ? occ_rd_dq  : '0;
  assign occ_arr_cur = occ_vld_arr ? occ_rd_arr : '0;
  assign occ_dq_dec  = (occ_dq_cur == '0) ? '0 : occ_dq_cur - pqta_pkg::CountBits'(1);
  assign same_q      = cmd.dq_en && (cmd.dq_addr == cmd.arr_addr);
  assign thr_eff     = thr_vld_rd ? thr_rd : thr_default;
  assign occ_inc     = arr_occ + pqta_pkg::CountBits'(1);

  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == S_ARR) && out_free;
  assign judged   = (cmd.kind == pqta_pkg::KIND_TRAFFIC) && cmd.arr_valid;
  assign admit    = judged && cmd.arr_hit && (arr_occ < thr_eff);
  assign thr_we   = finish && (cmd.kind == pqta_pkg::KIND_WRITE_ONE) && cmd.arr_hit;

  // single occupancy write port: dequeue written in S_DEQ, arrival later in S_ARR
  always_comb begin
    occ_we = 1'b0;
    occ_wa = cmd.arr_addr;
    occ_wd = occ_inc;
    priority if ((state == S_DEQ) && cmd.dq_en) begin
      occ_we = 1'b1;
      occ_wa = cmd.dq_addr;
      occ_wd = occ_dq_dec;
    end else if (finish && admit) begin
      occ_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      occ_rd_dq   <= occ_mem[head.dq_addr];
      occ_rd_arr  <= occ_mem[head.arr_addr];
      thr_rd      <= thr_mem[head.arr_addr];
      occ_vld_dq  <= occ_vld[head.dq_addr];
      occ_vld_arr <= occ_vld[head.arr_addr];
      thr_vld_rd  <= thr_vld[head.arr_addr];
    end
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (thr_we) begin
      thr_mem[cmd.arr_addr] <= cmd.thr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      occ_vld     <= '0;
      thr_vld     <= '0;
      thr_default <= '1;
    end else begin
      if (out_valid && !out_stall && !finish) begin
        out_valid <= 1'b0;
      end
      if (occ_we) begin
        occ_vld[occ_wa] <= 1'b1;
      end
      if (thr_we) begin
        thr_vld[cmd.arr_addr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            cmd   <= head;
            state <= (head.kind == pqta_pkg::KIND_TRAFFIC) ? S_DEQ : S_ARR;
          end
        end
        S_DEQ: begin
          // arrival sees the decrement of a dequeue on the same queue
          arr_occ <= same_q ? occ_dq_dec : occ_arr_cur;
          state   <= S_ARR;
        end
        S_ARR: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            decision_valid  <= judged;
            decision_queue  <= judged ? cmd.arr_queue : '0;
            dropped         <= judged && !admit;
            occupancy_after <= (judged && cmd.arr_hit) ?
                               pqta_pkg::CountFieldBits'(admit ? occ_inc : arr_occ) : '0;
            unique case (cmd.kind)
              pqta_pkg::KIND_TRAFFIC:   ;
              pqta_pkg::KIND_WRITE_ONE: ;
              pqta_pkg::KIND_WRITE_ALL: begin
                thr_default <= cmd.thr;
                thr_vld     <= '0;
              end
              pqta_pkg::KIND_CLEAR: begin
                occ_vld <= '0;
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/per_queue_threshold_admission_top.sv
// ----------------------------------------------------------------------------
// per_queue_threshold_admission_top
// Per-queue tail-drop admission: occupancy counts and drop thresholds per
// virtual output queue, with single/bulk threshold writes and count clear.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_stall | operation, dequeue_*, arrival_*, threshold
//   out     | out_valid/out_stall | decision_valid, decision_queue, dropped,
//           |                     | occupancy_after
//
// traffic requests go S_IDLE, S_DEQ, S_ARR in the engine, others skip S_DEQ;
// the engine reads the tables once per request and owns one occupancy write
// port, so dequeue and arrival updates go in separate cycles
// bulk threshold write and count clear take effect at once via per-entry
// valid bits, no clearing pass after reset
// a two-entry command queue lets the input keep accepting while a result
// waits on out_stall
// ----------------------------------------------------------------------------
module per_queue_threshold_admission_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic                                 dequeue_valid,
  input  logic [pqta_pkg::QueueFieldBits-1:0]  dequeue_queue,
  input  logic                                 arrival_valid,
  input  logic [pqta_pkg::QueueFieldBits-1:0]  arrival_queue,
  input  logic [pqta_pkg::CountFieldBits-1:0]  threshold_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 decision_valid,
  output logic [pqta_pkg::QueueFieldBits-1:0]  decision_queue,
  output logic                                 dropped,
  output logic [pqta_pkg::CountFieldBits-1:0]  occupancy_after
);

  pqta_pkg::cmd_t push_cmd;
  pqta_pkg::cmd_t head_cmd;
  logic           push;
  logic           fifo_full;
  logic           head_valid;
  logic           pop;

  pqta_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .dequeue_valid   (dequeue_valid),
    .dequeue_queue   (dequeue_queue),
    .arrival_valid   (arrival_valid),
    .arrival_queue   (arrival_queue),
    .threshold_value (threshold_value),
    .fifo_full       (fifo_full),
    .push            (push),
    .cmd             (push_cmd)
  );

  pqta_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (head_valid),
    .dout      (head_cmd)
  );

  pqta_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head            (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .decision_valid  (decision_valid),
    .decision_queue  (decision_queue),
    .dropped         (dropped),
    .occupancy_after (occupancy_after)
  );

endmodule

FILE: rtl/pqta_checker.sv
// ----------------------------------------------------------------------------
// pqta_checker
// Port-level checks on the admission block's result channel.
// ----------------------------------------------------------------------------
module pqta_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 decision_valid,
  input logic [pqta_pkg::QueueFieldBits-1:0]  decision_queue,
  input logic                                 dropped,
  input logic [pqta_pkg::CountFieldBits-1:0]  occupancy_after
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(decision_valid)
      && $stable(decision_queue) && $stable(dropped) && $stable(occupancy_after))
    else $error("result changed while stalled");

  // no arrival judged means an all-zero result
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !decision_valid |-> !dropped && decision_queue == '0
      && occupancy_after == '0)
    else $error("non-judged result carries data");

  // a passed packet was counted, so its queue is not empty
  a_pass_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && decision_valid && !dropped |-> occupancy_after != '0)
    else $error("passed packet with zero occupancy");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // a stalled request with no result pending stays offered or the stall clears
  a_stall_no_result_loss: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall && !out_valid |=> !in_stall || in_valid)
    else $error("input stall state inconsistent");

endmodule

bind per_queue_threshold_admission_top pqta_checker u_pqta_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .decision_valid  (decision_valid),
  .decision_queue  (decision_queue),
  .dropped         (dropped),
  .occupancy_after (occupancy_after)
);
